// ===== hw/rtl/efu_pkg.sv =====
// shared types, constants and codes of the event frame byte unstuff decoder
package efu_pkg;

    localparam int PACKET_BYTES = 12;
    localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
    localparam int IDX_W        = $clog2(PACKET_BYTES);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [7:0] t_byte;

    localparam t_byte START_BYTE  = 8'h5B;
    localparam t_byte END_BYTE    = 8'h5D;
    localparam t_byte ESC_BYTE    = 8'h1B;
    localparam t_byte ESC_OFFSET  = 8'h20;
    localparam t_byte ESC_OK_START = START_BYTE + ESC_OFFSET;
    localparam t_byte ESC_OK_END   = END_BYTE + ESC_OFFSET;
    localparam t_byte ESC_OK_ESC   = ESC_BYTE + ESC_OFFSET;
    localparam t_byte SIZE_MAX    = 8'hFF;

    // packet byte positions
    localparam int BYTE_LEVEL  = 0;
    localparam int BYTE_FORMAT = 1;
    localparam int BYTE_SOURCE = 2;
    localparam int BYTE_EVENT  = 3;
    localparam int BYTE_TIME   = 4;
    localparam int BYTE_DATA   = 8;

    // payload format codes
    localparam t_byte FMT_NONE   = 8'd0;
    localparam t_byte FMT_BOOL   = 8'd1;
    localparam t_byte FMT_S8     = 8'd2;
    localparam t_byte FMT_U8     = 8'd3;
    localparam t_byte FMT_S16    = 8'd4;
    localparam t_byte FMT_U16    = 8'd5;
    localparam t_byte FMT_S32    = 8'd6;
    localparam t_byte FMT_U32    = 8'd7;
    localparam t_byte FMT_FLOAT  = 8'd8;
    localparam t_byte FMT_STRING = 8'd9;

    typedef logic [PACKET_BYTES-1:0][7:0] t_packet;

    typedef struct packed {
        logic    valid;
        t_byte   size;
        t_packet bytes;
    } t_frame_rec;

    typedef struct packed {
        logic        valid_res;
        t_byte       frame_size;
        logic [3:0]  level;
        t_byte       source_id;
        t_byte       event_id;
        logic [31:0] timestamp;
        logic [3:0]  data_type;
        logic [31:0] data_value;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_ctl;

endpackage

// ===== hw/rtl/efu_ifs.sv =====
// request and result channel interfaces
interface efu_in_if;
    logic          valid;
    logic          ready;
    efu_pkg::t_byte frame_byte;
    logic          buffer_last;
    modport source(output valid, output frame_byte, output buffer_last, input ready);
    modport sink(input valid, input frame_byte, input buffer_last, output ready);
endinterface

interface efu_out_if;
    logic           valid;
    logic           ready;
    logic           valid_res;
    efu_pkg::t_byte frame_size;
    logic [3:0]     level;
    efu_pkg::t_byte source_id;
    efu_pkg::t_byte event_id;
    logic [31:0]    timestamp;
    logic [3:0]     data_type;
    logic [31:0]    data_value;
    modport source(output valid, output valid_res, output frame_size, output level,
                   output source_id, output event_id, output timestamp,
                   output data_type, output data_value, input ready);
    modport sink(input valid, input valid_res, input frame_size, input level,
                 input source_id, input event_id, input timestamp,
                 input data_type, input data_value, output ready);
endinterface

// ===== hw/rtl/efu_front.sv =====
// front end: byte classification, unstuffing and frame state
module efu_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    efu_in_if.sink              i_req,
    output efu_pkg::t_q_ctl     o_ctl_push,
    input  efu_pkg::t_q_ctl     i_ctl_full,
    output efu_pkg::t_frame_rec o_rec
);

    logic                     r_start, n_start;
    logic                     r_esc, n_esc;
    logic [efu_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                     r_ovf, n_ovf;
    efu_pkg::t_byte           r_cons, n_cons;
    efu_pkg::t_packet         r_pkt;

    efu_pkg::t_byte b;
    efu_pkg::t_byte cons_inc;
    efu_pkg::t_byte gbyte;
    logic accept, is_start, esc_path, bad_esc, end_path, esc_set, gather, emit, room;

    assign i_req.ready = !i_ctl_full.full;
    assign accept      = i_req.valid && i_req.ready;
    assign b           = i_req.frame_byte;

    always_comb begin
        cons_inc = (r_cons == efu_pkg::SIZE_MAX) ? r_cons : r_cons + 8'd1;
        is_start = !r_start && (b == efu_pkg::START_BYTE);
        esc_path = !is_start && r_esc;
        bad_esc  = esc_path && (b != efu_pkg::ESC_OK_START) && (b != efu_pkg::ESC_OK_END)
                   && (b != efu_pkg::ESC_OK_ESC);
        end_path = !is_start && !r_esc && (b == efu_pkg::END_BYTE);
        esc_set  = !is_start && !r_esc && !end_path && (b == efu_pkg::ESC_BYTE);
        gather   = esc_path || (!is_start && !r_esc && !end_path && !esc_set);
        gbyte    = esc_path ? b - efu_pkg::ESC_OFFSET : b;
        emit     = bad_esc || end_path || i_req.buffer_last;
        room     = r_cnt < efu_pkg::CNT_W'(efu_pkg::PACKET_BYTES);
    end

    always_comb begin
        n_start = r_start;
        n_esc   = r_esc;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_cons  = r_cons;
        if (accept) begin
            if (emit) begin
                n_start = 1'b0;
                n_esc   = 1'b0;
                n_cnt   = '0;
                n_ovf   = 1'b0;
                n_cons  = '0;
            end else begin
                n_cons = cons_inc;
                if (is_start) begin
                    n_start = 1'b1;
                end
                if (esc_path) begin
                    n_esc = 1'b0;
                end else if (esc_set) begin
                    n_esc = 1'b1;
                end
                if (gather) begin
                    if (room) begin
                        n_cnt = r_cnt + efu_pkg::CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
            r_esc   <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_cons  <= '0;
        end else begin
            r_start <= n_start;
            r_esc   <= n_esc;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_cons  <= n_cons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && gather && room) begin
            r_pkt[r_cnt[efu_pkg::IDX_W-1:0]] <= gbyte;
        end
    end

    assign o_ctl_push.push = accept && emit;
    assign o_ctl_push.full = 1'b0;
    assign o_rec.valid = end_path && r_start && !r_ovf
                         && (r_cnt == efu_pkg::CNT_W'(efu_pkg::PACKET_BYTES));
    assign o_rec.size  = cons_inc;
    assign o_rec.bytes = r_pkt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= efu_pkg::CNT_W'(efu_pkg::PACKET_BYTES))
        else $error("packet count beyond packet size");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_cnt == efu_pkg::CNT_W'(efu_pkg::PACKET_BYTES)))
        else $error("overflow flagged with packet not full");

    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && emit) |=> (r_cons == '0 && !r_start && !r_esc && r_cnt == '0))
        else $error("frame state not cleared after result");

endmodule

// ===== hw/rtl/efu_queue.sv =====
// short queue of finished frame records between front and back
module efu_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  efu_pkg::t_q_ctl     i_ctl_push,
    output efu_pkg::t_q_ctl     o_ctl_full,
    input  efu_pkg::t_frame_rec i_rec,
    output logic                o_valid,
    input  logic                i_pop,
    output efu_pkg::t_frame_rec o_rec
);

    efu_pkg::t_frame_rec        r_mem [efu_pkg::QUEUE_DEPTH];
    logic [efu_pkg::QPTR_W-1:0] r_wp;
    logic [efu_pkg::QPTR_W-1:0] r_rp;
    logic [efu_pkg::QCNT_W-1:0] r_cnt;
    logic push, pop;

    assign o_ctl_full.full = (r_cnt == efu_pkg::QCNT_W'(efu_pkg::QUEUE_DEPTH));
    assign o_ctl_full.push = 1'b0;
    assign o_valid         = (r_cnt != '0);
    assign push            = i_ctl_push.push && !o_ctl_full.full;
    assign pop             = i_pop && o_valid;
    assign o_rec           = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == efu_pkg::QPTR_W'(efu_pkg::QUEUE_DEPTH - 1)) ? '0
                        : r_wp + efu_pkg::QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == efu_pkg::QPTR_W'(efu_pkg::QUEUE_DEPTH - 1)) ? '0
                        : r_rp + efu_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + efu_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - efu_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl_push.push |-> !o_ctl_full.full)
        else $error("record pushed into full queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= efu_pkg::QCNT_W'(efu_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - efu_pkg::QCNT_W'(1)))
        else $error("queue count not reduced on pop");

endmodule

// ===== hw/rtl/efu_back.sv =====
// back end: packet decode and result register
module efu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_pop,
    input  efu_pkg::t_frame_rec i_rec,
    efu_out_if.source           o_res
);

    logic                r_valid;
    efu_pkg::t_out_item  r_item;
    efu_pkg::t_out_item  n_item;
    efu_pkg::t_byte      fmt;
    logic [31:0]         raw;
    logic                load;

    assign load  = !r_valid || o_res.ready;
    assign o_pop = i_valid && load;

    always_comb begin
        fmt = i_rec.bytes[efu_pkg::BYTE_FORMAT];
        raw = {i_rec.bytes[efu_pkg::BYTE_DATA+3], i_rec.bytes[efu_pkg::BYTE_DATA+2],
               i_rec.bytes[efu_pkg::BYTE_DATA+1], i_rec.bytes[efu_pkg::BYTE_DATA]};
        n_item            = '0;
        n_item.frame_size = i_rec.size;
        if (i_rec.valid) begin
            n_item.valid_res = 1'b1;
            n_item.level     = i_rec.bytes[efu_pkg::BYTE_LEVEL][7:4];
            n_item.source_id = i_rec.bytes[efu_pkg::BYTE_SOURCE];
            n_item.event_id  = i_rec.bytes[efu_pkg::BYTE_EVENT];
            n_item.timestamp = {i_rec.bytes[efu_pkg::BYTE_TIME+3],
                                i_rec.bytes[efu_pkg::BYTE_TIME+2],
                                i_rec.bytes[efu_pkg::BYTE_TIME+1],
                                i_rec.bytes[efu_pkg::BYTE_TIME]};
            case (fmt)
                efu_pkg::FMT_BOOL, efu_pkg::FMT_S8, efu_pkg::FMT_U8: begin
                    n_item.data_type  = fmt[3:0];
                    n_item.data_value = {24'd0, raw[7:0]};
                end
                efu_pkg::FMT_S16, efu_pkg::FMT_U16: begin
                    n_item.data_type  = fmt[3:0];
                    n_item.data_value = {16'd0, raw[15:0]};
                end
                efu_pkg::FMT_S32, efu_pkg::FMT_U32, efu_pkg::FMT_FLOAT,
                efu_pkg::FMT_STRING: begin
                    n_item.data_type  = fmt[3:0];
                    n_item.data_value = raw;
                end
                default: begin
                    n_item.data_type  = efu_pkg::FMT_NONE[3:0];
                    n_item.data_value = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.valid_res  = r_item.valid_res;
    assign o_res.frame_size = r_item.frame_size;
    assign o_res.level      = r_item.level;
    assign o_res.source_id  = r_item.source_id;
    assign o_res.event_id   = r_item.event_id;
    assign o_res.timestamp  = r_item.timestamp;
    assign o_res.data_type  = r_item.data_type;
    assign o_res.data_value = r_item.data_value;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_item.valid_res) |-> (r_item.timestamp == '0 && r_item.data_value == '0
                                            && r_item.data_type == '0 && r_item.level == '0))
        else $error("invalid frame with nonzero fields");

    a_type_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_item.data_type <= efu_pkg::FMT_STRING[3:0]))
        else $error("data type out of range");

    a_pop_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped record not shown");

endmodule

// ===== hw/rtl/event_frame_byte_unstuff_decoder.sv =====
// top level of the event frame byte unstuff decoder
//
//  channel  dir  handshake      payload
//  i_req    in   valid/ready    frame_byte[7:0], buffer_last
//  o_res    out  valid/ready    valid_res, frame_size, level, source_id, event_id,
//                               timestamp, data_type, data_value
//
// one request per cycle unless the queue is full; the front end settles each byte in the
// cycle it is taken; a result passes through the queue and the result register to o_res; the
// two-entry queue and result register let the front keep taking bytes while a result waits
// i_req.ready drops only while the queue is full; synchronous active-low reset
// clears control state, the packet bytes are not reset
module event_frame_byte_unstuff_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    efu_in_if.sink    i_req,
    efu_out_if.source o_res
);

    efu_pkg::t_q_ctl     ctl_push;
    efu_pkg::t_q_ctl     ctl_full;
    efu_pkg::t_frame_rec front_rec;
    efu_pkg::t_frame_rec back_rec;
    logic                q_valid;
    logic                q_pop;

    efu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_ctl_push (ctl_push),
        .i_ctl_full (ctl_full),
        .o_rec      (front_rec)
    );

    efu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl_push (ctl_push),
        .o_ctl_full (ctl_full),
        .i_rec      (front_rec),
        .o_valid    (q_valid),
        .i_pop      (q_pop),
        .o_rec      (back_rec)
    );

    efu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_rec   (back_rec),
        .o_res   (o_res)
    );

endmodule
